### rtl/core/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg
// Types and constants shared by the debounced flow meter core: operation
// codes, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package dfm_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_PULSE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_PPL       = 2'd1;
    localparam logic [1:0] REG_CAL       = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE  = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // Register reset values.
    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [23:0] PPL_RST      = 24'd115200;
    localparam logic [23:0] CAL_RST      = 24'd65536;
    localparam logic [15:0] DEBOUNCE_RST = 16'd1000;

    // Milliseconds per minute, used as a multiplier operand.
    localparam logic [23:0] MS_PER_MIN = 24'd60000;

    // Shared multiplier and divider geometry.
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 24;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DEN_W     = 56;
    localparam int QUO_W     = 32;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_MUL_GAIN,
        ST_MUL_DEN,
        ST_DIV_RATE_INIT,
        ST_DIV_RATE,
        ST_MUL_VOL,
        ST_DIV_VOL_INIT,
        ST_DIV_VOL,
        ST_DONE
    } dfm_state_t;

endpackage

`default_nettype wire

### rtl/core/debounced_flow_meter_core.sv
// ----------------------------------------------------------------------------
// debounced_flow_meter_core
// Pulse-rate flow meter with debounced pulse counting and fixed point
// flow rate and volume, computed on one shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one transaction per event: a pulse edge with its
//   microsecond time, a read with its millisecond time, or a volume clear.
//   Pulse edges and clears complete in the cycle they are taken and produce
//   no result. A read produces exactly one result transaction on the m_
//   channel: flow in L/min and volume in L, both unsigned Q8.24, truncated
//   and saturated.
//   A served read goes from acceptance to the result register through four
//   products on the shared 48x24 multiplier (three rate products, one
//   volume product), a setup state before each of the two 32-step
//   restoring divisions at one quotient bit per cycle, and a hand-over state.
//   A disabled read goes from acceptance straight to the hand-over state.
//   s_ready is high only while the sequencer is idle, so no transaction is
//   taken while a read is worked on; pulse and clear transactions sustain
//   one per cycle.
//   The result sits in an output register: a new transaction is taken while
//   it waits, and a following read holds in its last state until the
//   receiver has taken the earlier result.
//   Configuration writes are always ready. Synchronous reset restores the
//   register defaults and clears the count, snapshot and time stamps.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_flow_meter_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dfm_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_op,
    input  wire logic [31:0]                       s_time_us,
    input  wire logic [31:0]                       s_time_ms,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_valid_res,
    output logic [31:0]                            m_flow_lpm,
    output logic [31:0]                            m_volume
);

    import dfm_pkg::*;

    // Configuration registers.
    logic        enable_reg;
    logic [23:0] ppl_reg;
    logic [23:0] cal_reg;
    logic [15:0] debounce_reg;

    // Architectural state.
    logic [31:0] pulse_count_reg;
    logic [31:0] last_pulse_time_reg;
    logic [31:0] count_snapshot_reg;
    logic [31:0] last_read_time_reg;

    // Working registers of a read.
    logic [31:0]          delta_reg;
    logic [31:0]          cur_reg;
    logic [31:0]          dt_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_P_W-1:0]   num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     lo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 sat_reg;
    logic                 res_ok_reg;
    logic [31:0]          flow_res_reg;
    logic [31:0]          vol_res_reg;

    // Output register.
    logic        m_valid_reg;
    logic        m_valid_res_reg;
    logic [31:0] m_flow_lpm_reg;
    logic [31:0] m_volume_reg;

    dfm_state_t state_reg;
    dfm_state_t state_next;

    logic                 s_fire;
    logic                 out_free;
    logic                 read_served;
    logic [31:0]          us_since;
    logic [31:0]          ms_since;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [DEN_W:0]       div_trial;
    logic [DEN_W:0]       div_diff;
    logic                 div_ge;
    logic [DEN_W-1:0]     rem_step;
    logic [QUO_W-1:0]     lo_step;
    logic                 div_last;

    assign cfg_ready = 1'b1;

    assign s_fire      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign read_served = enable_reg && (ppl_reg != '0);
    assign us_since    = s_time_us - last_pulse_time_reg;
    assign ms_since    = s_time_ms - last_read_time_reg;

    // Shared multiplier.
    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    // One restoring division step: shift in the next dividend bit, trial
    // subtract, and shift the quotient bit in where the dividend bit left.
    assign div_trial = {rem_reg, lo_reg[QUO_W-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign rem_step  = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
    assign lo_step   = {lo_reg[QUO_W-2:0], div_ge};
    assign div_last  = (div_cnt_reg == DIV_CNT_W'(QUO_W - 1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_op == OP_READ) begin
                    state_next = read_served ? ST_MUL_RATE : ST_DONE;
                end
            end
            ST_MUL_RATE:      state_next = ST_MUL_GAIN;
            ST_MUL_GAIN:      state_next = ST_MUL_DEN;
            ST_MUL_DEN:       state_next = ST_DIV_RATE_INIT;
            ST_DIV_RATE_INIT: state_next = ST_DIV_RATE;
            ST_DIV_RATE: begin
                if (div_last) begin
                    state_next = ST_MUL_VOL;
                end
            end
            ST_MUL_VOL:       state_next = ST_DIV_VOL_INIT;
            ST_DIV_VOL_INIT:  state_next = ST_DIV_VOL;
            ST_DIV_VOL: begin
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:          state_next = ST_IDLE;
        endcase
    end

    // State-dependent outputs: handshake and multiplier operand selection.
    always_comb begin
        s_ready = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_MUL_RATE: begin
                mul_a = MUL_A_W'(delta_reg);
                mul_b = MS_PER_MIN;
            end
            ST_MUL_GAIN: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = cal_reg;
            end
            ST_MUL_DEN: begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = ppl_reg;
            end
            ST_MUL_VOL: begin
                mul_a = MUL_A_W'(cur_reg);
                mul_b = cal_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= ENABLE_RST;
            ppl_reg      <= PPL_RST;
            cal_reg      <= CAL_RST;
            debounce_reg <= DEBOUNCE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLE:   enable_reg   <= cfg_data[0];
                REG_PPL:      ppl_reg      <= cfg_data[23:0];
                REG_CAL:      cal_reg      <= cfg_data[23:0];
                REG_DEBOUNCE: debounce_reg <= cfg_data[15:0];
                default:      enable_reg   <= enable_reg;
            endcase
        end
    end

    // Pulse counting, clearing and read bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg     <= '0;
            last_pulse_time_reg <= '0;
            count_snapshot_reg  <= '0;
            last_read_time_reg  <= '0;
        end else if (s_fire) begin
            case (s_op)
                OP_PULSE: begin
                    if (us_since >= {16'd0, debounce_reg}) begin
                        pulse_count_reg     <= pulse_count_reg + 32'd1;
                        last_pulse_time_reg <= s_time_us;
                    end
                end
                OP_CLEAR: begin
                    pulse_count_reg    <= '0;
                    count_snapshot_reg <= '0;
                end
                OP_READ: begin
                    if (read_served) begin
                        count_snapshot_reg <= pulse_count_reg;
                        last_read_time_reg <= s_time_ms;
                    end
                end
                default: begin
                    pulse_count_reg <= pulse_count_reg;
                end
            endcase
        end
    end

    // Read datapath: operands, products and the shared divider.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    div_cnt_reg <= '0;
                    if (s_fire && s_op == OP_READ) begin
                        delta_reg    <= pulse_count_reg - count_snapshot_reg;
                        cur_reg      <= pulse_count_reg;
                        dt_reg       <= (ms_since == '0) ? 32'd1 : ms_since;
                        res_ok_reg   <= read_served;
                        flow_res_reg <= '0;
                        vol_res_reg  <= '0;
                    end
                end
                ST_MUL_RATE, ST_MUL_GAIN, ST_MUL_VOL: begin
                    prod_reg <= mul_p;
                end
                ST_MUL_DEN: begin
                    // Keep the rate numerator while the product holds the divisor.
                    num_reg  <= prod_reg;
                    prod_reg <= mul_p;
                end
                ST_DIV_RATE_INIT: begin
                    // Numerator is num * 256; the quotient overflows 32 bits
                    // exactly when its upper bits reach the divisor.
                    den_reg     <= prod_reg[DEN_W-1:0];
                    sat_reg     <= ({8'd0, num_reg[MUL_P_W-1:24]} >= prod_reg[DEN_W-1:0]);
                    rem_reg     <= {8'd0, num_reg[MUL_P_W-1:24]};
                    lo_reg      <= {num_reg[23:0], 8'd0};
                    div_cnt_reg <= '0;
                end
                ST_DIV_VOL_INIT: begin
                    den_reg     <= {32'd0, ppl_reg};
                    sat_reg     <= (prod_reg[55:24] >= {8'd0, ppl_reg});
                    rem_reg     <= {24'd0, prod_reg[55:24]};
                    lo_reg      <= {prod_reg[23:0], 8'd0};
                    div_cnt_reg <= '0;
                end
                ST_DIV_RATE, ST_DIV_VOL: begin
                    rem_reg     <= rem_step;
                    lo_reg      <= lo_step;
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_last) begin
                        if (state_reg == ST_DIV_RATE) begin
                            flow_res_reg <= sat_reg ? '1 : lo_step;
                        end else begin
                            vol_res_reg  <= sat_reg ? '1 : lo_step;
                        end
                    end
                end
                default: begin
                    div_cnt_reg <= '0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_valid_res_reg <= res_ok_reg;
            m_flow_lpm_reg  <= flow_res_reg;
            m_volume_reg    <= vol_res_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = m_valid_res_reg;
    assign m_flow_lpm  = m_flow_lpm_reg;
    assign m_volume    = m_volume_reg;

    // An invalid result always carries zero flow and volume.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_flow_lpm == '0 && m_volume == '0))
        else $error("invalid result carries nonzero payload");

    // A clear empties both the count and the snapshot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_op == OP_CLEAR) |=> (pulse_count_reg == '0 && count_snapshot_reg == '0))
        else $error("clear did not empty the count");

    // A served read takes the snapshot of the current count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_op == OP_READ && read_served)
            |=> (count_snapshot_reg == $past(pulse_count_reg)))
        else $error("read snapshot mismatch");

    // The divider step counter only runs in the division states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DIV_RATE && state_reg != ST_DIV_VOL) |=>
            ($past(state_reg) == ST_DIV_RATE || $past(state_reg) == ST_DIV_VOL ||
             div_cnt_reg == '0))
        else $error("divider counter ran outside a division");

    // The pulse count never changes while a read is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |-> $stable(pulse_count_reg))
        else $error("pulse count changed during a read");

endmodule

`default_nettype wire
